### rtl/tspc_pkg.sv
// ----------------------------------------------------------------------------
// tspc_pkg
// Shared types and constants of the train speed PI controller.
// ----------------------------------------------------------------------------
package tspc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int SPEED_W       = 7;
  localparam int TEMP_W        = 8;
  localparam int POWER_W       = 32;
  localparam int INT_W         = 48;
  localparam int HALF_W        = 24;
  localparam int MUL_A_W       = CFG_W + 1;
  localparam int MUL_B_W_DEF   = FRAC_BITS_DEF + 10;
  localparam int SPEED_MAX     = 43;
  localparam int POWER_CAP     = 120000;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd2;

  typedef enum logic [3:0] {
    ACT_SPEED_UP    = 4'd0,
    ACT_SPEED_DOWN  = 4'd1,
    ACT_BRAKE       = 4'd2,
    ACT_TEMP_DOWN   = 4'd3,
    ACT_TEMP_UP     = 4'd4,
    ACT_LEFT_DOORS  = 4'd5,
    ACT_RIGHT_DOORS = 4'd6,
    ACT_LIGHTS      = 4'd7,
    ACT_AUTO        = 4'd8,
    ACT_EBRAKE      = 4'd9,
    ACT_CMD_SPEED   = 4'd10,
    ACT_CUR_SPEED   = 4'd11
  } action_t;

endpackage

### rtl/tspc_mul.sv
// ----------------------------------------------------------------------------
// tspc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tspc_mul #(
  parameter int A_W = tspc_pkg::MUL_A_W,
  parameter int B_W = tspc_pkg::MUL_B_W_DEF
) (
  input  logic                     clk,
  input  logic signed [A_W-1:0]    a,
  input  logic signed [B_W-1:0]    b,
  output logic signed [A_W+B_W-1:0] p_r
);
  import tspc_pkg::*;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

### rtl/train_speed_pi_controller.sv
// ----------------------------------------------------------------------------
// train_speed_pi_controller
// Operator and train event processor with a trapezoidal PI power loop.
//
//   channel | handshake         | payload
//   --------+-------------------+--------------------------------------------
//   in      | in_valid/in_stall | in_action, in_speed_value
//   out     | out_valid/out_stall | power, set/current speed, temp, flags
//   cfg     | cfg_we            | cfg_index, cfg_wdata
//
// Speed up, speed down and current speed events run the PI update: five passes
// through the one shared multiplier plus the saturating add, clamp and final
// compare steps between them. All other events give their result in the cycle
// after the transaction. A result waits in the output register; a new
// transaction is taken once the block is idle and that register is empty or
// being emptied. Reset initialises valid, event, config and integrator state.
// ----------------------------------------------------------------------------
module train_speed_pi_controller #(
  parameter int FRAC_BITS = tspc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [3:0]                        in_action,
  input  logic [tspc_pkg::SPEED_W-1:0]      in_speed_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tspc_pkg::POWER_W-1:0] out_power_watts,
  output logic                              out_power_updated,
  output logic [tspc_pkg::SPEED_W-1:0]      out_set_speed_out,
  output logic [tspc_pkg::SPEED_W-1:0]      out_current_speed_out,
  output logic signed [tspc_pkg::TEMP_W-1:0] out_cabin_temp,
  output logic                              out_brake_on,
  output logic                              out_ebrake_on,
  output logic                              out_auto_mode,
  output logic                              out_left_doors_open,
  output logic                              out_right_doors_open,
  output logic                              out_lights_on,
  input  logic                              cfg_we,
  input  logic [tspc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tspc_pkg::CFG_W-1:0]        cfg_wdata
);
  import tspc_pkg::*;

  localparam int CONV_W = FRAC_BITS + 1;
  localparam longint unsigned ConvFull =
    ((64'd160934 << FRAC_BITS) + 64'd50000) / 64'd100000;
  localparam logic [CONV_W-1:0] Conv = ConvFull[CONV_W-1:0];
  localparam int ERR_W  = FRAC_BITS + 9;
  localparam int SUM_W  = ERR_W + 1;
  localparam int MB_W   = (SUM_W > HALF_W + 1) ? SUM_W : HALF_W + 1;
  localparam int P_W    = MUL_A_W + MB_W;
  localparam int INC_W  = SUM_W + 8;
  localparam int KP_W   = CFG_W + HALF_W + 1;
  localparam logic signed [63:0] CapFix   = 64'(POWER_CAP) <<< FRAC_BITS;
  localparam logic signed [63:0] TermLim  = 64'sh4000_0000_0000_0000;
  localparam logic signed [63:0] Int32Min = -64'sd2147483648;
  localparam logic signed [INT_W-1:0] IntMax = {1'b0, {(INT_W-1){1'b1}}};
  localparam logic signed [INT_W-1:0] IntMin = {1'b1, {(INT_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_MERR, S_SUM, S_MINC, S_INTEG, S_MLO, S_MHI, S_KSUM, S_PSUM, S_DONE
  } state_t;

  state_t state_r;

  logic [CFG_W-1:0] prop_gain_r, integral_gain_r, sample_period_r;
  logic [SPEED_W-1:0] set_r, cur_r, cmd_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic brake_r, ebrake_r, auto_r, left_r, right_r, lights_r;
  logic signed [ERR_W-1:0] prev_r, err_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [INT_W-1:0] integ_r;
  logic signed [POWER_W-1:0] last_power_r;
  logic signed [63:0] pterm_r, ki_r, pwr_r;
  logic [KP_W-1:0] klo_r;
  logic out_valid_r;

  logic [SPEED_W-1:0] set_nxt, cur_nxt, cmd_nxt;
  logic signed [TEMP_W-1:0] temp_nxt;
  logic brake_nxt, ebrake_nxt, auto_nxt, left_nxt, right_nxt, lights_nxt;
  logic signed [POWER_W-1:0] power_evt_nxt, power_nxt;
  logic upd_nxt, pi_nxt;

  logic out_free, in_accept, out_load;
  logic signed [7:0] diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0] prod_r;
  logic signed [INC_W-1:0] inc;
  logic signed [INT_W:0] integ_sum;
  logic signed [INT_W-1:0] integ_nxt;
  logic signed [63:0] ki_nxt, ki_sat, pwr_sh;
  logic cap_hit;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_load  = (in_accept && !pi_nxt) || ((state_r == S_DONE) && out_free);

  always_comb begin
    set_nxt       = set_r;
    cur_nxt       = cur_r;
    cmd_nxt       = cmd_r;
    temp_nxt      = temp_r;
    brake_nxt     = brake_r;
    ebrake_nxt    = ebrake_r;
    auto_nxt      = auto_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    lights_nxt    = lights_r;
    power_evt_nxt = last_power_r;
    upd_nxt       = 1'b0;
    pi_nxt        = 1'b0;
    case (action_t'(in_action))
      ACT_SPEED_UP: begin
        set_nxt = (set_r >= SPEED_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX) : set_r + 1'b1;
        pi_nxt  = 1'b1;
      end
      ACT_SPEED_DOWN: begin
        set_nxt = (set_r <= SPEED_W'(1)) ? '0 : set_r - 1'b1;
        pi_nxt  = 1'b1;
      end
      ACT_BRAKE: begin
        cur_nxt       = '0;
        brake_nxt     = 1'b1;
        power_evt_nxt = '0;
        upd_nxt       = 1'b1;
      end
      ACT_TEMP_DOWN: begin
        if (temp_r != {1'b1, {(TEMP_W-1){1'b0}}}) temp_nxt = temp_r - 8'sd1;
      end
      ACT_TEMP_UP: begin
        if (temp_r != {1'b0, {(TEMP_W-1){1'b1}}}) temp_nxt = temp_r + 8'sd1;
      end
      ACT_LEFT_DOORS:  left_nxt   = !left_r;
      ACT_RIGHT_DOORS: right_nxt  = !right_r;
      ACT_LIGHTS:      lights_nxt = !lights_r;
      ACT_AUTO: begin
        auto_nxt = !auto_r;
        if (!auto_r) set_nxt = cmd_r;
      end
      ACT_EBRAKE: begin
        cur_nxt    = '0;
        ebrake_nxt = !ebrake_r;
      end
      ACT_CMD_SPEED: cmd_nxt = in_speed_value;
      ACT_CUR_SPEED: begin
        cur_nxt = in_speed_value;
        pi_nxt  = 1'b1;
      end
      default: ;
    endcase
  end

  assign diff = $signed({1'b0, set_r}) - $signed({1'b0, cur_r});

  always_comb begin
    mul_a = $signed({1'b0, integral_gain_r});
    mul_b = MB_W'($signed(integ_r[INT_W-1:HALF_W]));
    case (state_r)
      S_MERR: begin
        mul_a = MUL_A_W'(diff);
        mul_b = MB_W'($signed({1'b0, Conv}));
      end
      S_MINC: begin
        mul_a = $signed({1'b0, sample_period_r});
        mul_b = MB_W'(sum_r);
      end
      S_INTEG: begin
        mul_a = $signed({1'b0, prop_gain_r});
        mul_b = MB_W'(err_r);
      end
      S_MLO: begin
        mul_a = $signed({1'b0, integral_gain_r});
        mul_b = MB_W'($signed({1'b0, integ_r[HALF_W-1:0]}));
      end
      default: ;
    endcase
  end

  tspc_mul #(
    .A_W (MUL_A_W),
    .B_W (MB_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  assign inc       = $signed(prod_r[SUM_W+16:9]);
  assign integ_sum = (INT_W+1)'(integ_r) + (INT_W+1)'(inc);
  always_comb begin
    if (integ_sum[INT_W] != integ_sum[INT_W-1]) begin
      integ_nxt = integ_sum[INT_W] ? IntMin : IntMax;
    end else begin
      integ_nxt = integ_sum[INT_W-1:0];
    end
  end

  assign ki_nxt = (64'($signed(prod_r[KP_W-1:0])) <<< HALF_W) + 64'(klo_r);

  always_comb begin
    if (ki_r > TermLim) begin
      ki_sat = TermLim;
    end else if (ki_r < -TermLim) begin
      ki_sat = -TermLim;
    end else begin
      ki_sat = ki_r;
    end
  end

  assign cap_hit = pwr_r > CapFix;
  assign pwr_sh  = pwr_r >>> FRAC_BITS;
  always_comb begin
    if (cap_hit) begin
      power_nxt = POWER_W'(POWER_CAP);
    end else if (pwr_sh < Int32Min) begin
      power_nxt = Int32Min[POWER_W-1:0];
    end else begin
      power_nxt = pwr_sh[POWER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      prop_gain_r     <= '0;
      integral_gain_r <= '0;
      sample_period_r <= CFG_W'(256);
      set_r           <= '0;
      cur_r           <= '0;
      cmd_r           <= '0;
      temp_r          <= '0;
      brake_r         <= 1'b0;
      ebrake_r        <= 1'b0;
      auto_r          <= 1'b0;
      left_r          <= 1'b0;
      right_r         <= 1'b0;
      lights_r        <= 1'b0;
      prev_r          <= '0;
      integ_r         <= '0;
      last_power_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROP_GAIN:     prop_gain_r     <= cfg_wdata;
          CFG_INTEGRAL_GAIN: integral_gain_r <= cfg_wdata;
          CFG_SAMPLE_PERIOD: sample_period_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            set_r        <= set_nxt;
            cur_r        <= cur_nxt;
            cmd_r        <= cmd_nxt;
            temp_r       <= temp_nxt;
            brake_r      <= brake_nxt;
            ebrake_r     <= ebrake_nxt;
            auto_r       <= auto_nxt;
            left_r       <= left_nxt;
            right_r      <= right_nxt;
            lights_r     <= lights_nxt;
            last_power_r <= power_evt_nxt;
            if (pi_nxt) begin
              state_r <= S_MERR;
            end else begin
              out_power_watts       <= power_evt_nxt;
              out_power_updated     <= upd_nxt;
              out_set_speed_out     <= set_nxt;
              out_current_speed_out <= cur_nxt;
              out_cabin_temp        <= temp_nxt;
              out_brake_on          <= brake_nxt;
              out_ebrake_on         <= ebrake_nxt;
              out_auto_mode         <= auto_nxt;
              out_left_doors_open   <= left_nxt;
              out_right_doors_open  <= right_nxt;
              out_lights_on         <= lights_nxt;
            end
          end
        end
        S_MERR: state_r <= S_SUM;
        S_SUM: begin
          err_r   <= $signed(prod_r[ERR_W-1:0]);
          sum_r   <= SUM_W'($signed(prod_r[ERR_W-1:0])) + SUM_W'(prev_r);
          state_r <= S_MINC;
        end
        S_MINC: begin
          prev_r  <= err_r;
          state_r <= S_INTEG;
        end
        S_INTEG: begin
          integ_r <= integ_nxt;
          state_r <= S_MLO;
        end
        S_MLO: begin
          pterm_r <= 64'(prod_r);
          state_r <= S_MHI;
        end
        S_MHI: begin
          klo_r   <= prod_r[KP_W-1:0];
          state_r <= S_KSUM;
        end
        S_KSUM: begin
          ki_r    <= ki_nxt;
          state_r <= S_PSUM;
        end
        S_PSUM: begin
          pwr_r   <= pterm_r + ki_sat;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            last_power_r <= power_nxt;
            if (cap_hit) integ_r <= CapFix[INT_W-1:0];
            out_power_watts       <= power_nxt;
            out_power_updated     <= 1'b1;
            out_set_speed_out     <= set_r;
            out_current_speed_out <= cur_r;
            out_cabin_temp        <= temp_r;
            out_brake_on          <= brake_r;
            out_ebrake_on         <= ebrake_r;
            out_auto_mode         <= auto_r;
            out_left_doors_open   <= left_r;
            out_right_doors_open  <= right_r;
            out_lights_on         <= lights_r;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
